// ----- rtl/ramped_sine_voltage_source_defines.svh -----
// ----------------------------------------------------------------------------
// ramped sine voltage source: assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RAMPED_SINE_VOLTAGE_SOURCE_DEFINES_SVH
`define RAMPED_SINE_VOLTAGE_SOURCE_DEFINES_SVH

// same-cycle implication
`define RSVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rsvs_pkg.sv -----
// ----------------------------------------------------------------------------
// rsvs_pkg
// types, fixed-point constants and the arctangent table of the voltage source
// ----------------------------------------------------------------------------
package rsvs_pkg;

  localparam int CORDIC_STAGES_DEF = 24;

  localparam int DIV_STEPS = 32;
  localparam int MOD_STEPS = 27;
  localparam int MOD_W     = 65;
  localparam int CORDIC_ZW = 34;
  localparam int COS_XW    = 36;
  localparam int ROT_XW    = 52;
  localparam int PHASOR_W  = 49;

  localparam logic [31:0]                  PI_Q30       = 32'd3373259426;
  localparam logic signed [CORDIC_ZW-1:0]  PI_Z         = 34'sd3373259426;
  localparam logic signed [CORDIC_ZW-1:0]  HALF_PI_Z    = 34'sd1686629713;
  localparam logic signed [CORDIC_ZW-1:0]  TWO_PI_Z     = 34'sd6746518852;
  localparam logic [38:0]                  TWO_PI_Q36   = 39'd431777206545;
  localparam logic signed [30:0]           INV_GAIN_Q30 = 31'sd652032874;
  localparam logic signed [COS_XW-1:0]     COS_X0       = 36'sd2608131496;
  localparam logic [32:0]                  FADE_ONE     = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    REGION_BEFORE = 2'd0,
    REGION_RAMP   = 2'd1,
    REGION_AFTER  = 2'd2
  } region_e;

  typedef enum logic [3:0] {
    REG_REF_REAL     = 4'd0,
    REG_REF_IMAG     = 4'd1,
    REG_STEP_REAL    = 4'd2,
    REG_STEP_IMAG    = 4'd3,
    REG_BASE_FREQ    = 4'd4,
    REG_FREQ_STEP    = 4'd5,
    REG_SWITCH_START = 4'd6,
    REG_RAMP_LENGTH  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    region_e     region;
    logic [31:0] t;
  } div_side_t;

  typedef struct packed {
    region_e                      region;
    logic [31:0]                  t;
    logic signed [PHASOR_W-1:0]   pre;
    logic signed [PHASOR_W-1:0]   pim;
  } cos_side_t;

  typedef struct packed {
    region_e                      region;
    logic                         neg;
    logic signed [PHASOR_W-1:0]   pre;
    logic signed [PHASOR_W-1:0]   pim;
  } mod_side_t;

  localparam int DIV_SIDE_W = $bits(div_side_t);
  localparam int COS_SIDE_W = $bits(cos_side_t);
  localparam int MOD_SIDE_W = $bits(mod_side_t);
  localparam int ROT_SIDE_W = $bits(region_e);

  // atan(2^-i) in q30 radians
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd843314857;
      1:  a = 32'd497837829;
      2:  a = 32'd263043837;
      3:  a = 32'd133525159;
      4:  a = 32'd67021687;
      5:  a = 32'd33543516;
      6:  a = 32'd16775851;
      7:  a = 32'd8388437;
      8:  a = 32'd4194283;
      9:  a = 32'd2097149;
      10: a = 32'd1048576;
      11: a = 32'd524288;
      12: a = 32'd262144;
      13: a = 32'd131072;
      14: a = 32'd65536;
      15: a = 32'd32768;
      16: a = 32'd16384;
      17: a = 32'd8192;
      18: a = 32'd4096;
      19: a = 32'd2048;
      20: a = 32'd1024;
      21: a = 32'd512;
      22: a = 32'd256;
      23: a = 32'd128;
      24: a = 32'd64;
      25: a = 32'd32;
      26: a = 32'd16;
      27: a = 32'd8;
      28: a = 32'd4;
      29: a = 32'd2;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/rsvs_div_cell.sv -----
// ----------------------------------------------------------------------------
// rsvs_div_cell
// one restoring division step: one quotient bit per cell, registered
// ----------------------------------------------------------------------------
module rsvs_div_cell #(
  parameter int SIDE_W = rsvs_pkg::DIV_SIDE_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       divisor,
  input  logic              vld_i,
  input  logic [31:0]       rem_i,
  input  logic [31:0]       quo_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [31:0]       rem_o,
  output logic [31:0]       quo_o,
  output logic [SIDE_W-1:0] side_o
);
  import rsvs_pkg::*;

  logic              vld_r;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       quo_r, quo_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [32:0]       rem2;
  logic              ge;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    ge      = rem2 >= {1'b0, divisor};
    rem_nxt = ge ? 32'(rem2 - {1'b0, divisor}) : rem2[31:0];
    quo_nxt = {quo_i[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

// ----- rtl/rsvs_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// rsvs_cordic_cell
// one rotation-mode cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module rsvs_cordic_cell #(
  parameter int XW     = rsvs_pkg::COS_XW,
  parameter int STAGE  = 0,
  parameter int SIDE_W = rsvs_pkg::COS_SIDE_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic signed [XW-1:0]              x_i,
  input  logic signed [XW-1:0]              y_i,
  input  logic signed [rsvs_pkg::CORDIC_ZW-1:0] z_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              vld_o,
  output logic signed [XW-1:0]              x_o,
  output logic signed [XW-1:0]              y_o,
  output logic signed [rsvs_pkg::CORDIC_ZW-1:0] z_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import rsvs_pkg::*;

  localparam logic signed [CORDIC_ZW-1:0] ATAN_Z =
    CORDIC_ZW'(atan_q30(STAGE));

  logic                        vld_r;
  logic signed [XW-1:0]        x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [CORDIC_ZW-1:0] z_r, z_nxt;
  logic [SIDE_W-1:0]           side_r;

  always_comb begin
    dx = x_i >>> STAGE;
    dy = y_i >>> STAGE;
    if (!z_i[CORDIC_ZW-1]) begin
      x_nxt = x_i - dy;
      y_nxt = y_i + dx;
      z_nxt = z_i - ATAN_Z;
    end else begin
      x_nxt = x_i + dy;
      y_nxt = y_i - dx;
      z_nxt = z_i + ATAN_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

// ----- rtl/rsvs_mod_cell.sv -----
// ----------------------------------------------------------------------------
// rsvs_mod_cell
// one step of the modulo-2pi reduction: subtract the period times 2^K if it fits
// ----------------------------------------------------------------------------
module rsvs_mod_cell #(
  parameter int K      = 0,
  parameter int SIDE_W = rsvs_pkg::MOD_SIDE_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [rsvs_pkg::MOD_W-1:0]  rem_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [rsvs_pkg::MOD_W-1:0]  rem_o,
  output logic [SIDE_W-1:0]           side_o
);
  import rsvs_pkg::*;

  localparam logic [MOD_W-1:0] SUB = MOD_W'(TWO_PI_Q36) << K;

  logic              vld_r;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [SIDE_W-1:0] side_r;

  assign rem_nxt = (rem_i >= SUB) ? rem_i - SUB : rem_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rem_r  <= rem_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign side_o = side_r;

endmodule

// ----- rtl/ramped_sine_voltage_source.sv -----
// ----------------------------------------------------------------------------
// ramped_sine_voltage_source
// instantaneous voltage of a sine source whose phasor and frequency ramp
// ----------------------------------------------------------------------------
// Takes one request per clock, every cycle, with no stall: busy is always low.
// Each result shows on out_* with out_valid for one cycle, in request order;
// the receiver must take it then. The pipeline holds the 32-cell ramp-position
// divider, the 27-cell modulo-2pi reduction and the two cordic rows (fade
// cosine and output rotation). Configuration writes are always ready and must
// only be made while no request is in flight.
// ----------------------------------------------------------------------------
module ramped_sine_voltage_source #(
  parameter int CORDIC_STAGES = rsvs_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_sim_time,
  output logic               out_valid,
  output logic signed [31:0] out_voltage_out,
  output logic [1:0]         out_region,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rsvs_pkg::*;

  `include "ramped_sine_voltage_source_defines.svh"

  // configuration registers
  logic [31:0] ref_real_r, ref_imag_r, step_real_r, step_imag_r;
  logic [31:0] base_freq_r, freq_step_r, switch_start_r, ramp_length_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_real_r     <= '0;
      ref_imag_r     <= '0;
      step_real_r    <= '0;
      step_imag_r    <= '0;
      base_freq_r    <= '0;
      freq_step_r    <= '0;
      switch_start_r <= '0;
      ramp_length_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REF_REAL:     ref_real_r     <= cfg_data;
        REG_REF_IMAG:     ref_imag_r     <= cfg_data;
        REG_STEP_REAL:    step_real_r    <= cfg_data;
        REG_STEP_IMAG:    step_imag_r    <= cfg_data;
        REG_BASE_FREQ:    base_freq_r    <= cfg_data;
        REG_FREQ_STEP:    freq_step_r    <= cfg_data;
        REG_SWITCH_START: switch_start_r <= cfg_data;
        REG_RAMP_LENGTH:  ramp_length_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // s0: region decision and divider seed
  // --------------------------------------------------------------------------
  logic        s0_vld_r;
  logic [31:0] s0_rem_r;
  div_side_t   s0_side_r, s0_side_nxt;
  logic [32:0] win_end;

  always_comb begin
    win_end       = {1'b0, switch_start_r} + {1'b0, ramp_length_r};
    s0_side_nxt.t = in_sim_time;
    if (in_sim_time < switch_start_r) begin
      s0_side_nxt.region = REGION_BEFORE;
    end else if ({1'b0, in_sim_time} < win_end) begin
      s0_side_nxt.region = REGION_RAMP;
    end else begin
      s0_side_nxt.region = REGION_AFTER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    s0_rem_r  <= in_sim_time - switch_start_r;
    s0_side_r <= s0_side_nxt;
  end

  // --------------------------------------------------------------------------
  // ramp position r = ((t - switch) << 32) / ramp
  // --------------------------------------------------------------------------
  logic                  div_vld  [0:DIV_STEPS];
  logic [31:0]           div_rem  [0:DIV_STEPS];
  logic [31:0]           div_quo  [0:DIV_STEPS];
  logic [DIV_SIDE_W-1:0] div_side [0:DIV_STEPS];

  assign div_vld[0]  = s0_vld_r;
  assign div_rem[0]  = s0_rem_r;
  assign div_quo[0]  = '0;
  assign div_side[0] = s0_side_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rsvs_div_cell #(.SIDE_W(DIV_SIDE_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .divisor (ramp_length_r),
      .vld_i   (div_vld[j]),
      .rem_i   (div_rem[j]),
      .quo_i   (div_quo[j]),
      .side_i  (div_side[j]),
      .vld_o   (div_vld[j+1]),
      .rem_o   (div_rem[j+1]),
      .quo_o   (div_quo[j+1]),
      .side_o  (div_side[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // m: products with r
  // --------------------------------------------------------------------------
  div_side_t          div_end;
  logic               m_vld_r;
  div_side_t          m_side_r;
  logic [63:0]        m_za_r, m_za_nxt;
  logic signed [64:0] m_pre_r, m_pre_nxt, m_pim_r, m_pim_nxt;

  assign div_end   = div_side[DIV_STEPS];
  assign m_za_nxt  = {32'd0, div_quo[DIV_STEPS]} * {32'd0, PI_Q30};
  assign m_pre_nxt = $signed(step_real_r) * $signed({1'b0, div_quo[DIV_STEPS]});
  assign m_pim_nxt = $signed(step_imag_r) * $signed({1'b0, div_quo[DIV_STEPS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= div_vld[DIV_STEPS];
    end
    m_side_r <= div_end;
    m_za_r   <= m_za_nxt;
    m_pre_r  <= m_pre_nxt;
    m_pim_r  <= m_pim_nxt;
  end

  // --------------------------------------------------------------------------
  // p: phasor per region, cosine angle folded into [-pi/2, pi/2]
  // --------------------------------------------------------------------------
  logic                        p_vld_r;
  logic signed [COS_XW-1:0]    p_x_r, p_x_nxt;
  logic signed [CORDIC_ZW-1:0] p_z_r, p_z_nxt, za_z;
  cos_side_t                   p_side_r, p_side_nxt;
  logic signed [PHASOR_W-1:0]  base_re, base_im;
  logic signed [32:0]          sum_re, sum_im;

  always_comb begin
    za_z = $signed({2'b00, m_za_r[63:32]});
    if (za_z > HALF_PI_Z) begin
      p_z_nxt = za_z - PI_Z;
      p_x_nxt = -COS_X0;
    end else begin
      p_z_nxt = za_z;
      p_x_nxt = COS_X0;
    end
    base_re = $signed({ref_real_r[31], ref_real_r, 16'd0});
    base_im = $signed({ref_imag_r[31], ref_imag_r, 16'd0});
    sum_re  = $signed({ref_real_r[31], ref_real_r}) + $signed({step_real_r[31], step_real_r});
    sum_im  = $signed({ref_imag_r[31], ref_imag_r}) + $signed({step_imag_r[31], step_imag_r});
    p_side_nxt.region = m_side_r.region;
    p_side_nxt.t      = m_side_r.t;
    case (m_side_r.region)
      REGION_RAMP: begin
        p_side_nxt.pre = base_re + $signed(m_pre_r[64:16]);
        p_side_nxt.pim = base_im + $signed(m_pim_r[64:16]);
      end
      REGION_AFTER: begin
        p_side_nxt.pre = $signed({sum_re, 16'd0});
        p_side_nxt.pim = $signed({sum_im, 16'd0});
      end
      default: begin
        p_side_nxt.pre = base_re;
        p_side_nxt.pim = base_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= m_vld_r;
    end
    p_x_r    <= p_x_nxt;
    p_z_r    <= p_z_nxt;
    p_side_r <= p_side_nxt;
  end

  // --------------------------------------------------------------------------
  // cos(pi*r) cordic row
  // --------------------------------------------------------------------------
  logic                        cos_vld  [0:CORDIC_STAGES];
  logic signed [COS_XW-1:0]    cos_x    [0:CORDIC_STAGES];
  logic signed [COS_XW-1:0]    cos_y    [0:CORDIC_STAGES];
  logic signed [CORDIC_ZW-1:0] cos_z    [0:CORDIC_STAGES];
  logic [COS_SIDE_W-1:0]       cos_side [0:CORDIC_STAGES];

  assign cos_vld[0]  = p_vld_r;
  assign cos_x[0]    = p_x_r;
  assign cos_y[0]    = '0;
  assign cos_z[0]    = p_z_r;
  assign cos_side[0] = p_side_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cos
    rsvs_cordic_cell #(.XW(COS_XW), .STAGE(k), .SIDE_W(COS_SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (cos_vld[k]),
      .x_i    (cos_x[k]),
      .y_i    (cos_y[k]),
      .z_i    (cos_z[k]),
      .side_i (cos_side[k]),
      .vld_o  (cos_vld[k+1]),
      .x_o    (cos_x[k+1]),
      .y_o    (cos_y[k+1]),
      .z_o    (cos_z[k+1]),
      .side_o (cos_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // f1..f6: fade, angular frequency, |w| * t
  // --------------------------------------------------------------------------
  cos_side_t          cos_end;
  logic signed [36:0] fade_num;
  logic [35:0]        fade_half;

  logic               f1_vld_r;
  logic [32:0]        f1_fade_r, f1_fade_nxt;
  cos_side_t          f1_side_r;

  assign cos_end   = cos_side[CORDIC_STAGES];
  assign fade_num  = $signed(37'h1_0000_0000)
                   - $signed({cos_x[CORDIC_STAGES][COS_XW-1], cos_x[CORDIC_STAGES]});
  assign fade_half = 36'(fade_num >>> 1);

  always_comb begin
    if (fade_num[36]) begin
      f1_fade_nxt = '0;
    end else if (fade_half > 36'(FADE_ONE)) begin
      f1_fade_nxt = FADE_ONE;
    end else begin
      f1_fade_nxt = fade_half[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= cos_vld[CORDIC_STAGES];
    end
    f1_fade_r <= f1_fade_nxt;
    f1_side_r <= cos_end;
  end

  logic               f2_vld_r;
  logic               f2_full_r;
  logic signed [64:0] f2_prod_r, f2_prod_nxt;
  cos_side_t          f2_side_r;

  assign f2_prod_nxt = $signed({1'b0, f1_fade_r[31:0]}) * $signed(freq_step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
    f2_full_r <= f1_fade_r[32];
    f2_prod_r <= f2_prod_nxt;
    f2_side_r <= f1_side_r;
  end

  logic               f3_vld_r;
  logic signed [33:0] f3_w_r, f3_w_nxt, wb34, ws34, fade_term;
  cos_side_t          f3_side_r;

  always_comb begin
    wb34      = $signed({{2{base_freq_r[31]}}, base_freq_r});
    ws34      = $signed({{2{freq_step_r[31]}}, freq_step_r});
    fade_term = f2_full_r ? ws34 : $signed({f2_prod_r[64], f2_prod_r[64:32]});
    case (f2_side_r.region)
      REGION_RAMP:  f3_w_nxt = wb34 + fade_term;
      REGION_AFTER: f3_w_nxt = wb34 + ws34;
      default:      f3_w_nxt = wb34;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_vld_r <= 1'b0;
    end else begin
      f3_vld_r <= f2_vld_r;
    end
    f3_w_r    <= f3_w_nxt;
    f3_side_r <= f2_side_r;
  end

  logic        f4_vld_r;
  logic        f4_neg_r;
  logic [32:0] f4_mag_r;
  cos_side_t   f4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f4_vld_r <= 1'b0;
    end else begin
      f4_vld_r <= f3_vld_r;
    end
    f4_neg_r  <= f3_w_r[33];
    f4_mag_r  <= f3_w_r[33] ? 33'(-f3_w_r) : f3_w_r[32:0];
    f4_side_r <= f3_side_r;
  end

  logic        f5_vld_r;
  logic        f5_neg_r;
  logic        f5_hi_r;
  logic [63:0] f5_prod_r;
  cos_side_t   f5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f5_vld_r <= 1'b0;
    end else begin
      f5_vld_r <= f4_vld_r;
    end
    f5_neg_r  <= f4_neg_r;
    f5_hi_r   <= f4_mag_r[32];
    f5_prod_r <= {32'd0, f4_mag_r[31:0]} * {32'd0, f4_side_r.t};
    f5_side_r <= f4_side_r;
  end

  // angle in q29.36 before reduction
  logic             f6_vld_r;
  logic [MOD_W-1:0] f6_ang_r, f6_ang_nxt;
  mod_side_t        f6_side_r, f6_side_nxt;

  always_comb begin
    f6_ang_nxt         = {1'b0, f5_prod_r}
                       + (f5_hi_r ? {1'b0, f5_side_r.t, 32'd0} : '0);
    f6_side_nxt.region = f5_side_r.region;
    f6_side_nxt.neg    = f5_neg_r;
    f6_side_nxt.pre    = f5_side_r.pre;
    f6_side_nxt.pim    = f5_side_r.pim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f6_vld_r <= 1'b0;
    end else begin
      f6_vld_r <= f5_vld_r;
    end
    f6_ang_r  <= f6_ang_nxt;
    f6_side_r <= f6_side_nxt;
  end

  // --------------------------------------------------------------------------
  // reduction modulo 2pi, one period multiple per cell
  // --------------------------------------------------------------------------
  logic                  mod_vld  [0:MOD_STEPS];
  logic [MOD_W-1:0]      mod_rem  [0:MOD_STEPS];
  logic [MOD_SIDE_W-1:0] mod_side [0:MOD_STEPS];

  assign mod_vld[0]  = f6_vld_r;
  assign mod_rem[0]  = f6_ang_r;
  assign mod_side[0] = f6_side_r;

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    rsvs_mod_cell #(.K(MOD_STEPS - 1 - j), .SIDE_W(MOD_SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (mod_vld[j]),
      .rem_i  (mod_rem[j]),
      .side_i (mod_side[j]),
      .vld_o  (mod_vld[j+1]),
      .rem_o  (mod_rem[j+1]),
      .side_o (mod_side[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // z1..z3: sign of w, q30 angle, wrap to (-pi, pi], fold by negation
  // --------------------------------------------------------------------------
  mod_side_t   mod_end;
  logic [38:0] mod_low, mod_adj;

  logic        z1_vld_r;
  logic [32:0] z1_zu_r;
  mod_side_t   z1_side_r;

  assign mod_end = mod_side[MOD_STEPS];
  assign mod_low = mod_rem[MOD_STEPS][38:0];
  assign mod_adj = (mod_end.neg && mod_low != '0) ? TWO_PI_Q36 - mod_low : mod_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_vld_r <= 1'b0;
    end else begin
      z1_vld_r <= mod_vld[MOD_STEPS];
    end
    z1_zu_r   <= mod_adj[38:6];
    z1_side_r <= mod_end;
  end

  logic                        z2_vld_r;
  logic signed [CORDIC_ZW-1:0] z2_z_r, z2_z_nxt, zu_s;
  mod_side_t                   z2_side_r;

  always_comb begin
    zu_s     = $signed({1'b0, z1_zu_r});
    z2_z_nxt = (zu_s > PI_Z) ? zu_s - TWO_PI_Z : zu_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z2_vld_r <= 1'b0;
    end else begin
      z2_vld_r <= z1_vld_r;
    end
    z2_z_r    <= z2_z_nxt;
    z2_side_r <= z1_side_r;
  end

  logic                        z3_vld_r;
  logic signed [ROT_XW-1:0]    z3_x_r, z3_x_nxt, z3_y_r, z3_y_nxt, pre_x, pim_x;
  logic signed [CORDIC_ZW-1:0] z3_z_r, z3_z_nxt;
  region_e                     z3_region_r;

  always_comb begin
    pre_x = ROT_XW'(z2_side_r.pre);
    pim_x = ROT_XW'(z2_side_r.pim);
    if (z2_z_r > HALF_PI_Z) begin
      z3_z_nxt = z2_z_r - PI_Z;
      z3_x_nxt = -pre_x;
      z3_y_nxt = -pim_x;
    end else if (z2_z_r < -HALF_PI_Z) begin
      z3_z_nxt = z2_z_r + PI_Z;
      z3_x_nxt = -pre_x;
      z3_y_nxt = -pim_x;
    end else begin
      z3_z_nxt = z2_z_r;
      z3_x_nxt = pre_x;
      z3_y_nxt = pim_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z3_vld_r <= 1'b0;
    end else begin
      z3_vld_r <= z2_vld_r;
    end
    z3_x_r      <= z3_x_nxt;
    z3_y_r      <= z3_y_nxt;
    z3_z_r      <= z3_z_nxt;
    z3_region_r <= z2_side_r.region;
  end

  // --------------------------------------------------------------------------
  // output rotation cordic row
  // --------------------------------------------------------------------------
  logic                        rot_vld  [0:CORDIC_STAGES];
  logic signed [ROT_XW-1:0]    rot_x    [0:CORDIC_STAGES];
  logic signed [ROT_XW-1:0]    rot_y    [0:CORDIC_STAGES];
  logic signed [CORDIC_ZW-1:0] rot_z    [0:CORDIC_STAGES];
  logic [ROT_SIDE_W-1:0]       rot_side [0:CORDIC_STAGES];

  assign rot_vld[0]  = z3_vld_r;
  assign rot_x[0]    = z3_x_r;
  assign rot_y[0]    = z3_y_r;
  assign rot_z[0]    = z3_z_r;
  assign rot_side[0] = z3_region_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    rsvs_cordic_cell #(.XW(ROT_XW), .STAGE(k), .SIDE_W(ROT_SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (rot_vld[k]),
      .x_i    (rot_x[k]),
      .y_i    (rot_y[k]),
      .z_i    (rot_z[k]),
      .side_i (rot_side[k]),
      .vld_o  (rot_vld[k+1]),
      .x_o    (rot_x[k+1]),
      .y_o    (rot_y[k+1]),
      .z_o    (rot_z[k+1]),
      .side_o (rot_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // o1, o2: gain removal and saturation
  // --------------------------------------------------------------------------
  logic                     o1_vld_r;
  logic signed [66:0]       o1_prod_r, o1_prod_nxt;
  logic [ROT_SIDE_W-1:0]    o1_region_r;
  logic signed [ROT_XW-17:0] rot_q16;

  assign rot_q16     = rot_x[CORDIC_STAGES][ROT_XW-1:16];
  assign o1_prod_nxt = rot_q16 * INV_GAIN_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r <= 1'b0;
    end else begin
      o1_vld_r <= rot_vld[CORDIC_STAGES];
    end
    o1_prod_r   <= o1_prod_nxt;
    o1_region_r <= rot_side[CORDIC_STAGES];
  end

  logic signed [36:0] volt_full;
  logic signed [31:0] volt_nxt;

  always_comb begin
    volt_full = o1_prod_r[66:30];
    if (volt_full > 37'sd2147483647) begin
      volt_nxt = 32'sh7FFF_FFFF;
    end else if (volt_full < -37'sd2147483648) begin
      volt_nxt = 32'sh8000_0000;
    end else begin
      volt_nxt = volt_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= o1_vld_r;
    end
    out_voltage_out <= volt_nxt;
    out_region      <= o1_region_r;
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `RSVS_ASSERT_NOW(a_ramp_has_length,
    s0_vld_r && s0_side_r.region == REGION_RAMP, ramp_length_r != '0,
    "ramp region chosen with zero ramp length")
  `RSVS_ASSERT_NEXT(a_cos_angle_folded, m_vld_r,
    p_z_r <= HALF_PI_Z && p_z_r >= -HALF_PI_Z,
    "fade angle outside [-pi/2, pi/2]")
  `RSVS_ASSERT_NOW(a_fade_clamped, f1_vld_r, f1_fade_r <= FADE_ONE,
    "fade factor above one")
  `RSVS_ASSERT_NOW(a_mod_reduced, mod_vld[MOD_STEPS],
    mod_rem[MOD_STEPS] < MOD_W'(TWO_PI_Q36),
    "angle not reduced below 2pi")
  `RSVS_ASSERT_NOW(a_rot_angle_folded, z3_vld_r,
    z3_z_r <= HALF_PI_Z && z3_z_r >= -HALF_PI_Z,
    "rotation angle outside [-pi/2, pi/2]")

endmodule
